[rtl/core/chacha20_stream_cipher_macros.svh]
// Assertion macros for the ChaCha20 stream cipher checker.
// Expects signals clk and rst_n in the scope of each use.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, off while in reset
`define CC20_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define CC20_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too
`define CC20_ASSERT_RST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cc20_pkg.sv]
// Package for the ChaCha20 stream cipher: types, constants, register codes.
// No dependencies; used by cc20_arx, cc20_block_gen and chacha20_stream_cipher.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

  localparam int CC20_DOUBLE_ROUNDS = 10;
  localparam int WORDS              = 16;
  localparam int BLOCK_BYTES        = 64;
  localparam int POS_W              = $clog2(BLOCK_BYTES);
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;

  typedef logic [31:0] word_t;

  // "expand 32-byte k"
  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  localparam word_t START_CNT_RST = 32'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0     = 3'd0,
    CFG_KEY_1     = 3'd1,
    CFG_KEY_2     = 3'd2,
    CFG_KEY_3     = 3'd3,
    CFG_NONCE_LO  = 3'd4,
    CFG_NONCE_HI  = 3'd5,
    CFG_START_CNT = 3'd6
  } cfg_idx_t;

  // Rotate amount of one ARX step, in quarter-round step order
  typedef enum logic [1:0] {
    ROT_16 = 2'd0,
    ROT_12 = 2'd1,
    ROT_8  = 2'd2,
    ROT_7  = 2'd3
  } arx_rot_t;

  // Block inputs handed to the generator
  typedef struct packed {
    word_t [7:0] key;
    word_t [2:0] nonce;
    word_t       counter;
  } blk_in_t;

  // Generator status
  typedef struct packed {
    logic busy;
    logic done;
  } gen_stat_t;

endpackage

`default_nettype wire

[rtl/core/cc20_if.sv]
// Valid/ready stream interfaces for the ChaCha20 stream cipher channels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       result_last;

  modport source (output valid, output result_byte, output result_last, input ready);
  modport sink   (input valid, input result_byte, input result_last, output ready);
endinterface

`default_nettype wire

[rtl/core/cc20_arx.sv]
// Shared ARX unit: one add, xor and rotate step of a quarter round.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc20_arx (
  input  cc20_pkg::word_t    x_i,
  input  cc20_pkg::word_t    y_i,
  input  cc20_pkg::word_t    z_i,
  input  cc20_pkg::arx_rot_t rot_i,
  output cc20_pkg::word_t    sum_o,
  output cc20_pkg::word_t    mix_o
);
  import cc20_pkg::*;

  word_t mixed;

  // x + y, then (z ^ sum) rotated left
  always_comb begin
    sum_o = x_i + y_i;
    mixed = z_i ^ sum_o;
    unique case (rot_i)
      ROT_16: mix_o = {mixed[15:0], mixed[31:16]};
      ROT_12: mix_o = {mixed[19:0], mixed[31:20]};
      ROT_8:  mix_o = {mixed[23:0], mixed[31:24]};
      ROT_7:  mix_o = {mixed[24:0], mixed[31:25]};
      default: mix_o = mixed;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cc20_block_gen.sv]
// Keystream block generator: 4x4 word state, one ARX step per cycle,
// then a feed-forward add of all 16 words into the keystream registers.
// Depends on cc20_pkg and cc20_arx.
`timescale 1ns / 1ps
`default_nettype none

module cc20_block_gen #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::CC20_DOUBLE_ROUNDS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  cc20_pkg::blk_in_t          blk_i,
  input  logic [cc20_pkg::POS_W-1:0] pos_i,
  output cc20_pkg::gen_stat_t        stat_o,
  output logic [7:0]                 ks_byte_o
);
  import cc20_pkg::*;

  localparam int DR_W  = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam int FIN_W = $clog2(WORDS);

  typedef enum logic [2:0] {
    GEN_IDLE  = 3'b001,
    GEN_ROUND = 3'b010,
    GEN_FINAL = 3'b100
  } gen_state_t;

  gen_state_t       state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [2:0]       qr_r, qr_nxt;
  logic [DR_W-1:0]  dr_r, dr_nxt;
  logic [FIN_W-1:0] fin_r, fin_nxt;
  logic             done_r, done_nxt;

  word_t st_r   [WORDS];
  word_t st_nxt [WORDS];
  word_t ks_r   [WORDS];
  word_t ks_nxt [WORDS];
  word_t init_w [WORDS];
  word_t upd    [WORDS];
  word_t rot_m  [WORDS];
  logic [1:0] row_rot [4];

  word_t    arx_x, arx_y, arx_z, arx_sum, arx_mix;
  arx_rot_t arx_rot;
  word_t    ks_word;

  // Initial state: constants, key, counter, nonce
  always_comb begin
    for (int i = 0; i < 4; i++) init_w[i] = SIGMA[i];
    for (int i = 0; i < 8; i++) init_w[4+i] = blk_i.key[i];
    init_w[12] = blk_i.counter;
    for (int i = 0; i < 3; i++) init_w[13+i] = blk_i.nonce[i];
  end

  // Operand select: even steps work on a/d, odd steps on c/b of column 0; final adds st[0] and an init word
  always_comb begin
    arx_rot = arx_rot_t'(step_r);
    if (state_r == GEN_FINAL) begin
      arx_x = st_r[0];
      arx_y = init_w[fin_r];
      arx_z = st_r[12];
    end else if (step_r[0]) begin
      arx_x = st_r[8];
      arx_y = st_r[12];
      arx_z = st_r[4];
    end else begin
      arx_x = st_r[0];
      arx_y = st_r[4];
      arx_z = st_r[12];
    end
  end

  cc20_arx u_arx (
    .x_i   (arx_x),
    .y_i   (arx_y),
    .z_i   (arx_z),
    .rot_i (arx_rot),
    .sum_o (arx_sum),
    .mix_o (arx_mix)
  );

  // Write back the step result into column 0
  always_comb begin
    upd = st_r;
    if (step_r[0]) begin
      upd[8] = arx_sum;
      upd[4] = arx_mix;
    end else begin
      upd[0]  = arx_sum;
      upd[12] = arx_mix;
    end
  end

  // Row rotation after each quarter round brings the next column to column 0.
  // End of column pass also diagonalizes, end of diagonal pass undoes it.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (qr_r == 3'd3) begin
        row_rot[r] = 2'(1 + r);
      end else if (qr_r == 3'd7) begin
        row_rot[r] = 2'(1 - r);
      end else begin
        row_rot[r] = 2'd1;
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        rot_m[4*r+c] = upd[{2'(r), 2'(c) + row_rot[r]}];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    qr_nxt    = qr_r;
    dr_nxt    = dr_r;
    fin_nxt   = fin_r;
    done_nxt  = 1'b0;
    st_nxt    = st_r;
    ks_nxt    = ks_r;
    unique case (state_r)
      GEN_IDLE: begin
        if (start_i) begin
          st_nxt    = init_w;
          step_nxt  = '0;
          qr_nxt    = '0;
          dr_nxt    = '0;
          state_nxt = GEN_ROUND;
        end
      end
      GEN_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          st_nxt = rot_m;
          qr_nxt = qr_r + 3'd1;
          if (qr_r == 3'd7) begin
            dr_nxt = dr_r + DR_W'(1);
            if (dr_r == DR_W'(DOUBLE_ROUNDS - 1)) begin
              fin_nxt   = '0;
              state_nxt = GEN_FINAL;
            end
          end
        end else begin
          st_nxt = upd;
        end
      end
      GEN_FINAL: begin
        // feed-forward add, state and keystream shift down one word a cycle
        for (int i = 0; i < WORDS - 1; i++) begin
          st_nxt[i] = st_r[i+1];
          ks_nxt[i] = ks_r[i+1];
        end
        ks_nxt[WORDS-1] = arx_sum;
        fin_nxt = fin_r + FIN_W'(1);
        if (fin_r == FIN_W'(WORDS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = GEN_IDLE;
        end
      end
      default: state_nxt = GEN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEN_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    qr_r   <= qr_nxt;
    dr_r   <= dr_nxt;
    fin_r  <= fin_nxt;
    st_r   <= st_nxt;
    ks_r   <= ks_nxt;
  end

  // Keystream byte, little-endian within each word
  assign ks_word   = ks_r[pos_i[POS_W-1:2]];
  assign ks_byte_o = ks_word[8*pos_i[1:0] +: 8];

  assign stat_o.busy = (state_r != GEN_IDLE);
  assign stat_o.done = done_r;

endmodule

`default_nettype wire

[rtl/core/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher top level: configuration registers, byte position,
// block counter and output register. Depends on cc20_pkg, cc20_if, cc20_block_gen.
//
// Usage:
//   in_stream  (valid/ready): text_byte plus is_last, one byte per transfer.
//   out_stream (valid/ready): result_byte = text_byte ^ keystream, result_last.
//   cfg_we/cfg_index/cfg_wdata: key, nonce and start counter, written while idle.
//   Writing the start counter restarts the stream at byte 0 of that block.
// Data flow:
//   Bytes 1..63 of a block: result the cycle after the transfer; one byte per cycle
//   while the output is not stalled. Byte 0 of a block starts the generator:
//   32 ARX steps per double round (ten by default) plus a feed-forward add of
//   16 words, then passes through the done flag, the emit state and the output
//   register. No byte is taken while a block is generated; the sustained rate
//   is set by the single shared ARX adder.
// Reset: synchronous; counter loads 1, position 0, key and nonce clear.
// Stall: a result waits in the output register; a new byte is taken in the
//   cycle the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::CC20_DOUBLE_ROUNDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cc20_in_if.sink                         in_stream,
  cc20_out_if.source                      out_stream,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    TOP_IDLE = 3'b001,
    TOP_GEN  = 3'b010,
    TOP_EMIT = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] key_r [4];
  logic [63:0]           nonce_lo_r;
  word_t                 nonce_hi_r;
  word_t                 start_cnt_r;
  word_t                 blk_cnt_r;
  logic [POS_W-1:0]      pos_r;

  logic [7:0] hold_byte_r;
  logic       hold_last_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  blk_in_t    blk_in;
  gen_stat_t  gen_stat;
  logic [7:0] ks_byte;
  logic       out_free, in_ready, in_fire, gen_start, emit_now, emit_last;
  logic [7:0] emit_byte;

  // Handshake
  assign out_free  = !out_valid_r || out_stream.ready;
  assign in_ready  = (state_r == TOP_IDLE) && !gen_stat.busy && out_free;
  assign in_fire   = in_stream.valid && in_ready;
  assign gen_start = in_fire && (pos_r == '0);
  assign emit_now  = (in_fire && (pos_r != '0)) || ((state_r == TOP_EMIT) && out_free);
  assign emit_byte = ((state_r == TOP_EMIT) ? hold_byte_r : in_stream.text_byte) ^ ks_byte;
  assign emit_last = (state_r == TOP_EMIT) ? hold_last_r : in_stream.is_last;

  // Block inputs
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      blk_in.key[2*i]   = key_r[i][31:0];
      blk_in.key[2*i+1] = key_r[i][63:32];
    end
    blk_in.nonce[0] = nonce_lo_r[31:0];
    blk_in.nonce[1] = nonce_lo_r[63:32];
    blk_in.nonce[2] = nonce_hi_r;
    blk_in.counter  = blk_cnt_r;
  end

  cc20_block_gen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_block_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (gen_start),
    .blk_i     (blk_in),
    .pos_i     (pos_r),
    .stat_o    (gen_stat),
    .ks_byte_o (ks_byte)
  );

  // Control FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TOP_IDLE: if (gen_start) state_nxt = TOP_GEN;
      TOP_GEN:  if (gen_stat.done) state_nxt = TOP_EMIT;
      TOP_EMIT: if (out_free) state_nxt = TOP_IDLE;
      default:  state_nxt = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TOP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, position and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_cnt_r <= START_CNT_RST;
      blk_cnt_r   <= START_CNT_RST;
      pos_r       <= '0;
    end else begin
      if (emit_now) begin
        if (emit_last) begin
          pos_r     <= '0;
          blk_cnt_r <= start_cnt_r;
        end else begin
          pos_r <= pos_r + POS_W'(1);
          if (pos_r == '1) blk_cnt_r <= blk_cnt_r + 32'd1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_KEY_0:    key_r[0]   <= cfg_wdata;
          CFG_KEY_1:    key_r[1]   <= cfg_wdata;
          CFG_KEY_2:    key_r[2]   <= cfg_wdata;
          CFG_KEY_3:    key_r[3]   <= cfg_wdata;
          CFG_NONCE_LO: nonce_lo_r <= cfg_wdata;
          CFG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
          CFG_START_CNT: begin
            start_cnt_r <= cfg_wdata[31:0];
            blk_cnt_r   <= cfg_wdata[31:0];
            pos_r       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Byte held while its block is generated
  always_ff @(posedge clk) begin
    if (gen_start) begin
      hold_byte_r <= in_stream.text_byte;
      hold_last_r <= in_stream.is_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign in_stream.ready        = in_ready;
  assign out_stream.valid       = out_valid_r;
  assign out_stream.result_byte = out_byte_r;
  assign out_stream.result_last = out_last_r;

endmodule

`default_nettype wire

[rtl/core/cc20_checker.sv]
// Port-level checker for the ChaCha20 stream cipher, bound to the top level.
// Depends on chacha20_stream_cipher_macros.svh and chacha20_stream_cipher.
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_stream_cipher_macros.svh"

module cc20_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_result_byte,
  input logic       out_result_last
);

  // Result stays offered until its transfer
  `CC20_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out valid dropped while stalled")

  // Stalled result keeps its payload
  `CC20_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_result_byte) && $stable(out_result_last), "out payload changed while stalled")

  // Never take a byte while the output register is full and stalled
  `CC20_ASSERT_IMP(a_no_overrun, in_ready, !out_valid || out_ready, "input ready with blocked output")

  // A byte either shows its result next cycle or makes the block busy
  `CC20_ASSERT_NXT(a_in_effect, in_valid && in_ready, out_valid || !in_ready, "input transfer had no effect")

  // Reset empties the output register
  `CC20_ASSERT_RST_NXT(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_stream.valid),
  .in_ready        (in_stream.ready),
  .out_valid       (out_stream.valid),
  .out_ready       (out_stream.ready),
  .out_result_byte (out_stream.result_byte),
  .out_result_last (out_stream.result_last)
);

`default_nettype wire
